/* hdl/tmb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmb_pkg: shared types and codes for the timer slot bank
// Transaction payload structs, operation and result codes, and the sequencer
// state type.
// ----------------------------------------------------------------------------
package tmb_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_STARTED = 3'd0;
  localparam logic [2:0] KIND_REFUSED = 3'd1;
  localparam logic [2:0] KIND_STOPPED = 3'd2;
  localparam logic [2:0] KIND_EXPIRY  = 3'd3;
  localparam logic [2:0] KIND_TICKED  = 3'd4;

  // input transaction
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] period;
    logic        periodic;
    logic        has_handler;
    logic [2:0]  slot;
  } tmb_req_t;

  // result transaction
  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot_index;
    logic       any_active;
    logic       last;
  } tmb_rsp_t;

  // slot store write controls
  typedef struct packed {
    logic we_start;   // load period, mode, clear count, set active
    logic we_count;   // write back stepped count
    logic clr_active; // deactivate the addressed slot
  } tmb_wr_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } tmb_state_t;

endpackage : tmb_pkg
`default_nettype wire

/* hdl/tmb_step_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmb_step_unit: shared count step and expiry compare
// Adds one to a slot count and compares the result against the slot period;
// an expiring count returns to zero.
// ----------------------------------------------------------------------------
module tmb_step_unit (
  input  wire logic [31:0] count,
  input  wire logic [31:0] period,
  output logic      [31:0] count_next,
  output logic             expire
);

  logic [31:0] count_inc;

  // increment with 32-bit wrap, then compare
  assign count_inc  = count + 32'd1;
  assign expire     = (count_inc >= period);
  assign count_next = expire ? 32'd0 : count_inc;

endmodule : tmb_step_unit
`default_nettype wire

/* hdl/tmb_slot_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmb_slot_store: per-slot timer state
// Holds period, count, mode and active flag of every slot. One write port
// and one read port, both addressed by slot index.
// ----------------------------------------------------------------------------
module tmb_slot_store #(
  parameter  int NUM_SLOTS = 8,
  localparam int IdxW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tmb_pkg::tmb_wr_t     wr,
  input  wire logic [IdxW-1:0]      wr_idx,
  input  wire logic [31:0]          wr_period,
  input  wire logic                 wr_periodic,
  input  wire logic [31:0]          wr_count,
  input  wire logic [IdxW-1:0]      rd_idx,
  output logic      [31:0]          rd_period,
  output logic      [31:0]          rd_count,
  output logic                      rd_periodic,
  output logic                      rd_active,
  output logic      [NUM_SLOTS-1:0] active
);

  import tmb_pkg::*;

  logic [31:0] slot_period   [NUM_SLOTS];
  logic [31:0] slot_count    [NUM_SLOTS];
  logic        slot_periodic [NUM_SLOTS];

  // payload state, valid only while the slot is active
  always_ff @(posedge clk) begin
    if (wr.we_start) begin
      slot_period[wr_idx]   <= wr_period;
      slot_periodic[wr_idx] <= wr_periodic;
      slot_count[wr_idx]    <= 32'd0;
    end else if (wr.we_count) begin
      slot_count[wr_idx] <= wr_count;
    end
  end

  // active flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (wr.we_start) begin
      active[wr_idx] <= 1'b1;
    end else if (wr.clr_active) begin
      active[wr_idx] <= 1'b0;
    end
  end

  // read port for the scan
  assign rd_period   = slot_period[rd_idx];
  assign rd_count    = slot_count[rd_idx];
  assign rd_periodic = slot_periodic[rd_idx];
  assign rd_active   = active[rd_idx];

endmodule : tmb_slot_store
`default_nettype wire

/* hdl/tmb_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmb_seq: transaction sequencer and result register
// Handles start, stop and reserved operations in the accept cycle, walks the
// slots one per cycle through the shared step unit on a tick, holding a slot
// while its expiry waits for the result register, and registers each result.
module tmb_seq #(
  parameter  int NUM_SLOTS = 8,
  localparam int IdxW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire tmb_pkg::tmb_req_t    req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output tmb_pkg::tmb_rsp_t         rsp,
  output tmb_pkg::tmb_wr_t          wr,
  output logic      [IdxW-1:0]      wr_idx,
  output logic      [31:0]          wr_period,
  output logic                      wr_periodic,
  output logic      [31:0]          wr_count,
  output logic      [IdxW-1:0]      rd_idx,
  input  wire logic                 rd_periodic,
  input  wire logic                 rd_active,
  input  wire logic [NUM_SLOTS-1:0] active,
  input  wire logic [31:0]          step_count,
  input  wire logic                 step_expire
);

  import tmb_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  tmb_state_t           state, state_next;
  logic [IdxW-1:0]      scan_idx;
  logic                 req_fire;
  logic                 rsp_free;
  logic                 rsp_load;
  tmb_rsp_t             rsp_next;
  logic                 scan_adv;
  logic                 free_found;
  logic [IdxW-1:0]      free_idx;
  logic                 stop_ok;
  logic [IdxW-1:0]      stop_idx;
  logic                 start_ok;
  logic [NUM_SLOTS-1:0] act_after;

  // handshake
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !rsp_free;
  assign req_fire  = req_valid && !req_stall;

  // lowest inactive slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (!active[j]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(j);
      end
    end
  end

  assign start_ok = req.has_handler && (req.period != 32'd0) && free_found;
  assign stop_ok  = ({3'b000, req.slot} < 6'(NUM_SLOTS));
  assign stop_idx = IdxW'(req.slot);

  // scan moves on unless an expiry waits for the result register
  assign scan_adv = !rd_active || !step_expire || rsp_free;
  assign rd_idx   = scan_idx;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && (req.func == FUNC_TICK)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_adv && (scan_idx == LastIdx)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // store writes and result contents
  always_comb begin
    wr          = '0;
    wr_idx      = scan_idx;
    wr_period   = req.period;
    wr_periodic = req.periodic;
    wr_count    = step_count;
    rsp_load    = 1'b0;
    rsp_next    = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          unique case (req.func)
            FUNC_TICK: begin
              rsp_load = 1'b0;
            end
            FUNC_START: begin
              rsp_load      = 1'b1;
              rsp_next.last = 1'b1;
              if (start_ok) begin
                wr.we_start         = 1'b1;
                wr_idx              = free_idx;
                rsp_next.kind       = KIND_STARTED;
                rsp_next.slot_index = 3'(free_idx);
              end else begin
                rsp_next.kind = KIND_REFUSED;
              end
            end
            FUNC_STOP: begin
              rsp_load      = 1'b1;
              rsp_next.last = 1'b1;
              rsp_next.kind = KIND_STOPPED;
              wr.clr_active = stop_ok;
              wr_idx        = stop_idx;
            end
            default: begin
              rsp_load      = 1'b1;
              rsp_next.last = 1'b1;
              rsp_next.kind = KIND_TICKED;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_active) begin
          if (!step_expire) begin
            wr.we_count = 1'b1;
          end else if (rsp_free) begin
            wr.we_count         = 1'b1;
            wr.clr_active       = !rd_periodic;
            rsp_load            = 1'b1;
            rsp_next.kind       = KIND_EXPIRY;
            rsp_next.slot_index = 3'(scan_idx);
          end
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp_load      = 1'b1;
          rsp_next.kind = KIND_TICKED;
          rsp_next.last = 1'b1;
        end
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
    // activity as it stands once this result's write lands
    act_after = active;
    if (wr.clr_active) act_after[wr_idx] = 1'b0;
    rsp_next.any_active = (|act_after) || wr.we_start;
  end

  // state and scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
    end else begin
      state <= state_next;
      if (state != ST_SCAN) begin
        scan_idx <= '0;
      end else if (scan_adv && (scan_idx != LastIdx)) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) rsp <= rsp_next;
  end

  // checks
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> req_stall)
    else $error("input taken while a tick is in progress");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req.func != FUNC_TICK)) |=> (rsp_valid && rsp.last))
    else $error("start or stop did not give a final result");

  a_tick_scans: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req.func == FUNC_TICK)) |=> ((state == ST_SCAN) && (scan_idx == '0)))
    else $error("tick did not start the slot walk at slot zero");

  a_start_active: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.kind == KIND_STARTED)) |-> rsp.any_active)
    else $error("started slot not reported active");

  a_write_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({wr.we_start, wr.we_count}))
    else $error("start load and count write in the same cycle");

endmodule : tmb_seq
`default_nettype wire

/* hdl/multi_slot_software_timer_bank.sv */
`timescale 1ns / 1ps
`default_nettype none
// Start, stop and reserved operations: the result is registered in the cycle
// after acceptance; the next transaction may be accepted in that cycle.
// Tick: the sequencer walks the slots one per cycle through one shared
// increment-and-compare unit, holding a slot while its expiry result is held
// back by a stalled output; no new transaction is accepted during the tick.
// Reset clears every active flag and the handshake state; no clearing pass.
// ----------------------------------------------------------------------------
// multi_slot_software_timer_bank: bank of periodic and one-shot timer slots
// Start claims the lowest free slot, stop frees a slot, tick advances every
// active slot and reports each expiry, followed by a tick done result.
// ----------------------------------------------------------------------------
module multi_slot_software_timer_bank #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire tmb_pkg::tmb_req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output tmb_pkg::tmb_rsp_t      rsp
);

  import tmb_pkg::*;

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  tmb_wr_t              wr;
  logic [IdxW-1:0]      wr_idx;
  logic [31:0]          wr_period;
  logic                 wr_periodic;
  logic [31:0]          wr_count;
  logic [IdxW-1:0]      rd_idx;
  logic [31:0]          rd_period;
  logic [31:0]          rd_count;
  logic                 rd_periodic;
  logic                 rd_active;
  logic [NUM_SLOTS-1:0] active;
  logic [31:0]          step_count;
  logic                 step_expire;

  // per-slot state
  tmb_slot_store #(.NUM_SLOTS(NUM_SLOTS)) u_store (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .wr_idx      (wr_idx),
    .wr_period   (wr_period),
    .wr_periodic (wr_periodic),
    .wr_count    (wr_count),
    .rd_idx      (rd_idx),
    .rd_period   (rd_period),
    .rd_count    (rd_count),
    .rd_periodic (rd_periodic),
    .rd_active   (rd_active),
    .active      (active)
  );

  // shared count step
  tmb_step_unit u_step (
    .count      (rd_count),
    .period     (rd_period),
    .count_next (step_count),
    .expire     (step_expire)
  );

  // sequencer and result register
  tmb_seq #(.NUM_SLOTS(NUM_SLOTS)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .wr          (wr),
    .wr_idx      (wr_idx),
    .wr_period   (wr_period),
    .wr_periodic (wr_periodic),
    .wr_count    (wr_count),
    .rd_idx      (rd_idx),
    .rd_periodic (rd_periodic),
    .rd_active   (rd_active),
    .active      (active),
    .step_count  (step_count),
    .step_expire (step_expire)
  );

endmodule : multi_slot_software_timer_bank
`default_nettype wire
